// ===== src/etm_pkg.sv =====
// Package for the Euler transform matrix unit: shared constants, CORDIC
// arctangent table, input item and column sideband types.
// No dependencies; every other file of the block but etm_if imports it.
package etm_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned ANGLE_BITS_DEF     = 16;
  localparam int unsigned TRIG_FRAC_BITS_DEF = 16;

  // CORDIC datapath: Q30 values with headroom.
  localparam int unsigned CORDIC_STEPS = 28;
  localparam int unsigned CW           = 34;
  localparam logic [31:0] CORDIC_GAIN  = 32'd652032874;

  // Restoring divider: dividend magnitude below 2^27, divisor up to 2^15.
  localparam int unsigned DIV_BITS = 27;
  localparam int unsigned REM_BITS = 16;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // Action codes.
  localparam logic ACT_MODEL  = 1'b0;
  localparam logic ACT_NORMAL = 1'b1;

  // Column codes.
  localparam logic [1:0] COL_NORMAL_LAST = 2'd2;
  localparam logic [1:0] COL_MOVE        = 2'd3;

  // Quadrant codes for the final quarter-turn rotation.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef logic signed [CW-1:0] cw_t;

  // One accepted transform.
  typedef struct packed {
    logic             action;
    logic [2:0][15:0] angle;
    logic [2:0][15:0] scale;
    logic [2:0][31:0] move;
  } in_item_t;

  // Column sideband that travels down the divider chain.
  typedef struct packed {
    logic [1:0]       column_index;
    logic             last_column;
    logic             zero_scale;
    logic             one;
    logic             use_div;
    logic [2:0]       neg;
    logic [15:0]      divisor;
    logic [2:0][31:0] elem;
  } col_side_t;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      15:      v = 32'h0000517D;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A30;
      19:      v = 32'h00000518;
      20:      v = 32'h0000028C;
      21:      v = 32'h00000146;
      22:      v = 32'h000000A3;
      23:      v = 32'h00000051;
      24:      v = 32'h00000029;
      25:      v = 32'h00000014;
      26:      v = 32'h0000000A;
      27:      v = 32'h00000005;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== src/etm_if.sv =====
// Channel interfaces of the Euler transform matrix unit: transform input
// and matrix column output. No dependencies.
interface etm_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] angle_x;
  logic [15:0] angle_y;
  logic [15:0] angle_z;
  logic [15:0] scale_x;
  logic [15:0] scale_y;
  logic [15:0] scale_z;
  logic [31:0] move_x;
  logic [31:0] move_y;
  logic [31:0] move_z;

  modport source (
    output valid, action, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z,
    output move_x, move_y, move_z,
    input  ready
  );
  modport sink (
    input  valid, action, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z,
    input  move_x, move_y, move_z,
    output ready
  );
endinterface

interface etm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  column_index;
  logic [31:0] elem_0;
  logic [31:0] elem_1;
  logic [31:0] elem_2;
  logic [31:0] elem_3;
  logic        zero_scale;
  logic        last_column;

  modport source (
    output valid, column_index, elem_0, elem_1, elem_2, elem_3, zero_scale,
    output last_column,
    input  ready
  );
  modport sink (
    input  valid, column_index, elem_0, elem_1, elem_2, elem_3, zero_scale,
    input  last_column,
    output ready
  );
endinterface

// ===== src/etm_cordic_cell.sv =====
// One CORDIC rotation cell of the sine/cosine chain, one angle lane.
// Depends on etm_pkg for the datapath type and the arctangent table.
module etm_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  etm_pkg::cw_t  x_i,
  input  etm_pkg::cw_t  y_i,
  input  etm_pkg::cw_t  z_i,
  input  logic [1:0]    q_i,
  output etm_pkg::cw_t  x_o,
  output etm_pkg::cw_t  y_o,
  output etm_pkg::cw_t  z_o,
  output logic [1:0]    q_o
);
  import etm_pkg::*;

  localparam cw_t ATAN = cw_t'(atan_turn(STEP));

  cw_t x_d, y_d, z_d;
  cw_t x_q, y_q, z_q;
  logic [1:0] q_q;

  // Rotate toward zero residual angle.
  always_comb begin
    if (!z_i[CW-1]) begin
      x_d = x_i - (y_i >>> STEP);
      y_d = y_i + (x_i >>> STEP);
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + (y_i >>> STEP);
      y_d = y_i - (x_i >>> STEP);
      z_d = z_i + ATAN;
    end
  end

  // Stage register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      q_q <= q_i;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
  assign q_o = q_q;
endmodule

// ===== src/etm_div_cell.sv =====
// One restoring-division cell: produces one quotient bit for each of the
// three rows of a column. Depends on etm_pkg for widths and sideband type.
module etm_div_cell (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  etm_pkg::col_side_t                    side_i,
  input  logic [2:0][etm_pkg::REM_BITS-1:0]     rem_i,
  input  logic [2:0][etm_pkg::DIV_BITS-1:0]     dq_i,
  output etm_pkg::col_side_t                    side_o,
  output logic [2:0][etm_pkg::REM_BITS-1:0]     rem_o,
  output logic [2:0][etm_pkg::DIV_BITS-1:0]     dq_o
);
  import etm_pkg::*;

  logic [2:0][REM_BITS-1:0] rem_d, rem_q;
  logic [2:0][DIV_BITS-1:0] dq_d, dq_q;
  col_side_t                side_q;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    logic [REM_BITS:0] r2;
    logic [REM_BITS:0] dv;
    logic              ge;
    dv = {1'b0, side_i.divisor};
    for (int l = 0; l < 3; l++) begin
      r2 = {rem_i[l], dq_i[l][DIV_BITS-1]};
      ge = (r2 >= dv);
      if (ge) begin
        r2 = r2 - dv;
      end
      rem_d[l] = r2[REM_BITS-1:0];
      dq_d[l]  = {dq_i[l][DIV_BITS-2:0], ge};
    end
  end

  // Stage register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      dq_q   <= dq_d;
      side_q <= side_i;
    end
  end

  assign side_o = side_q;
  assign rem_o  = rem_q;
  assign dq_o   = dq_q;
endmodule

// ===== src/euler_transform_matrix_unit.sv =====
// Euler Y-X-Z scale/rotate/translate matrix builder, top level.
// Depends on etm_pkg, etm_if, etm_cordic_cell and etm_div_cell.
//
// Usage: one transform enters on in_i (angles, Q8.8 scales, Q16.16 move,
// action); columns leave on out_o, one per transfer, column_index counting
// up from 0 and last_column set on the final one. Model action gives four
// columns (the fourth carries the move and 1.0), normal action gives three
// columns divided by the scales, with zero_scale set where a scale is zero.
// The columns of one transform leave out_o in consecutive cycles unless out_o
// stalls. The column serializer feeds one column per cycle into the divider
// chain while out_o is ready, and it takes the next transform only as it
// issues the last column of the current one (ser_free).
// Sine and cosine come from a chain of 28 CORDIC cells per angle, and the
// normal-matrix quotients from a chain of 27 restoring-division cells.
// Reset empties every stage; no clearing pass is needed.
// When out_o stalls, the output register holds its column and the chains
// hold in place; in_i.ready drops once the serializer cannot take more.
module euler_transform_matrix_unit #(
  parameter int unsigned ANGLE_BITS     = etm_pkg::ANGLE_BITS_DEF,
  parameter int unsigned TRIG_FRAC_BITS = etm_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  etm_in_if.sink    in_i,
  etm_out_if.source out_o
);
  import etm_pkg::*;

  localparam int unsigned TW      = TRIG_FRAC_BITS + 2;
  localparam int unsigned MW      = TRIG_FRAC_BITS + 3;
  localparam int unsigned PW      = 48;
  localparam int unsigned TRIG_SH = 30 - TRIG_FRAC_BITS;
  localparam int unsigned MOD_SH  = TRIG_FRAC_BITS - 8;
  localparam int unsigned NORM_SH = 24 - TRIG_FRAC_BITS;

  localparam logic signed [2*TW-1:0] MUL_HALF  = (2*TW)'(1) << (TRIG_FRAC_BITS - 1);
  localparam cw_t                    TRIG_HALF = cw_t'(1) << (TRIG_SH - 1);
  localparam logic signed [PW-1:0]   MOD_HALF  = PW'(1) << (MOD_SH - 1);
  localparam logic signed [PW-1:0]   P_MAX     = PW'(SAT_MAX);
  localparam logic signed [PW-1:0]   P_MIN     = -PW'(SAT_MAX) - PW'(1);

  // Trig product rounded half up back to the trig format.
  function automatic logic signed [TW-1:0] mul_t(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    p = a * b;
    p = p + MUL_HALF;
    p = p >>> TRIG_FRAC_BITS;
    return p[TW-1:0];
  endfunction

  function automatic logic signed [MW-1:0] ext_m(input logic signed [TW-1:0] a);
    return MW'(a);
  endfunction

  // ---------------------------------------------------------------------
  // Flow control.
  logic ov_q;
  logic mv_q;
  logic ser_v_q;
  logic [1:0] col_q;
  logic ser_act_q;
  logic ser_last, ser_free, en_out, en_front;

  assign en_out   = !ov_q || out_o.ready;
  assign ser_last = ser_v_q &&
                    (col_q == ((ser_act_q == ACT_NORMAL) ? COL_NORMAL_LAST : COL_MOVE));
  assign ser_free = !ser_v_q || ser_last;
  assign en_front = en_out && (ser_free || !mv_q);
  assign in_i.ready = en_front;

  // ---------------------------------------------------------------------
  // Input register.
  in_item_t in_d, in_q;
  logic     iv_q;

  assign in_d.action = in_i.action;
  assign in_d.angle  = {in_i.angle_z, in_i.angle_y, in_i.angle_x};
  assign in_d.scale  = {in_i.scale_z, in_i.scale_y, in_i.scale_x};
  assign in_d.move   = {in_i.move_z, in_i.move_y, in_i.move_x};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (en_front) begin
      iv_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_front && in_i.valid) begin
      in_q <= in_d;
    end
  end

  // ---------------------------------------------------------------------
  // Quadrant split and CORDIC start values.
  cw_t        cx_w [CORDIC_STEPS+1][3];
  cw_t        cy_w [CORDIC_STEPS+1][3];
  cw_t        cz_w [CORDIC_STEPS+1][3];
  logic [1:0] cq_w [CORDIC_STEPS+1][3];

  always_comb begin
    logic [31:0] a32;
    logic [31:0] ru;
    logic [31:0] qa;
    for (int l = 0; l < 3; l++) begin
      a32 = {16'b0, in_q.angle[l]} << (32 - ANGLE_BITS);
      qa  = a32 + 32'h2000_0000;
      ru  = a32 - {qa[31:30], 30'b0};
      cq_w[0][l] = qa[31:30];
      cx_w[0][l] = cw_t'(CORDIC_GAIN);
      cy_w[0][l] = '0;
      cz_w[0][l] = cw_t'(signed'(ru));
    end
  end

  // Row of CORDIC cells, three lanes per step.
  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
    for (genvar l = 0; l < 3; l++) begin : g_lane
      etm_cordic_cell #(.STEP(s)) u_cell (
        .clk_i (clk_i),
        .en_i  (en_front),
        .x_i   (cx_w[s][l]),
        .y_i   (cy_w[s][l]),
        .z_i   (cz_w[s][l]),
        .q_i   (cq_w[s][l]),
        .x_o   (cx_w[s+1][l]),
        .y_o   (cy_w[s+1][l]),
        .z_o   (cz_w[s+1][l]),
        .q_o   (cq_w[s+1][l])
      );
    end
  end

  // Valid bits and item sideband along the CORDIC chain.
  logic [CORDIC_STEPS-1:0] cv_q;
  in_item_t                cp_q [CORDIC_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else if (en_front) begin
      cv_q <= {cv_q[CORDIC_STEPS-2:0], iv_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_front) begin
      cp_q[0] <= in_q;
      for (int s = 1; s < CORDIC_STEPS; s++) begin
        cp_q[s] <= cp_q[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Quarter-turn rotation and rounding to the trig format.
  logic                   tv_q;
  in_item_t               tp_q;
  logic signed [TW-1:0]   tc_d [3], ts_d [3], tc_q [3], ts_q [3];

  always_comb begin
    cw_t xr, yr;
    for (int l = 0; l < 3; l++) begin
      case (cq_w[CORDIC_STEPS][l])
        QUAD_1: begin
          xr = -cy_w[CORDIC_STEPS][l];
          yr = cx_w[CORDIC_STEPS][l];
        end
        QUAD_2: begin
          xr = -cx_w[CORDIC_STEPS][l];
          yr = -cy_w[CORDIC_STEPS][l];
        end
        QUAD_3: begin
          xr = cy_w[CORDIC_STEPS][l];
          yr = -cx_w[CORDIC_STEPS][l];
        end
        default: begin
          xr = cx_w[CORDIC_STEPS][l];
          yr = cy_w[CORDIC_STEPS][l];
        end
      endcase
      xr = (xr + TRIG_HALF) >>> TRIG_SH;
      yr = (yr + TRIG_HALF) >>> TRIG_SH;
      tc_d[l] = xr[TW-1:0];
      ts_d[l] = yr[TW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= 1'b0;
    end else if (en_front) begin
      tv_q <= cv_q[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_front) begin
      tp_q <= cp_q[CORDIC_STEPS-1];
      tc_q <= tc_d;
      ts_q <= ts_d;
    end
  end

  // ---------------------------------------------------------------------
  // First products of sines and cosines (lanes: 0 = x, 1 = y, 2 = z).
  logic                 pv_q;
  in_item_t             pp_q;
  logic signed [TW-1:0] p_cycz, p_sysx, p_cxsz, p_cysx, p_czsy;
  logic signed [TW-1:0] p_cxcz, p_sysz, p_cxsy, p_cycx, p_cysz;
  logic signed [TW-1:0] p_sx, p_sz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en_front) begin
      pv_q <= tv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_front) begin
      pp_q   <= tp_q;
      p_cycz <= mul_t(tc_q[1], tc_q[2]);
      p_sysx <= mul_t(ts_q[1], ts_q[0]);
      p_cxsz <= mul_t(tc_q[0], ts_q[2]);
      p_cysx <= mul_t(tc_q[1], ts_q[0]);
      p_czsy <= mul_t(tc_q[2], ts_q[1]);
      p_cxcz <= mul_t(tc_q[0], tc_q[2]);
      p_sysz <= mul_t(ts_q[1], ts_q[2]);
      p_cxsy <= mul_t(tc_q[0], ts_q[1]);
      p_cycx <= mul_t(tc_q[1], tc_q[0]);
      p_cysz <= mul_t(tc_q[1], ts_q[2]);
      p_sx   <= ts_q[0];
      p_sz   <= ts_q[2];
    end
  end

  // ---------------------------------------------------------------------
  // Rotation matrix, indexed [column][row].
  in_item_t             mp_q;
  logic signed [MW-1:0] m_d [3][3], m_q [3][3];

  always_comb begin
    m_d[0][0] = ext_m(p_cycz) + ext_m(mul_t(p_sysx, p_sz));
    m_d[0][1] = ext_m(p_cxsz);
    m_d[0][2] = ext_m(mul_t(p_cysx, p_sz)) - ext_m(p_czsy);
    m_d[1][0] = ext_m(mul_t(p_czsy, p_sx)) - ext_m(p_cysz);
    m_d[1][1] = ext_m(p_cxcz);
    m_d[1][2] = ext_m(mul_t(p_cycz, p_sx)) + ext_m(p_sysz);
    m_d[2][0] = ext_m(p_cxsy);
    m_d[2][1] = -ext_m(p_sx);
    m_d[2][2] = ext_m(p_cycx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (en_front) begin
      mv_q <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_front) begin
      mp_q <= pp_q;
      m_q  <= m_d;
    end
  end

  // ---------------------------------------------------------------------
  // Column serializer: issues one column per cycle while the output is not stalled.
  logic signed [MW-1:0] ser_m_q [3][3];
  logic [2:0][15:0]     ser_sc_q;
  logic [2:0][31:0]     ser_mv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q <= 1'b0;
      col_q   <= '0;
    end else if (en_out) begin
      if (ser_free) begin
        ser_v_q <= mv_q;
        col_q   <= '0;
      end else begin
        col_q <= col_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && ser_free && mv_q) begin
      ser_m_q   <= m_q;
      ser_sc_q  <= mp_q.scale;
      ser_mv_q  <= mp_q.move;
      ser_act_q <= mp_q.action;
    end
  end

  // Scaling for model columns, dividend setup for normal columns.
  col_side_t                iss_side_d;
  logic [2:0][DIV_BITS-1:0] iss_dq_d;

  always_comb begin
    logic                 col3, normal, zero;
    logic [1:0]           jsel;
    logic signed [15:0]   s;
    logic [15:0]          ad;
    logic signed [MW-1:0] r;
    logic [MW-1:0]        rm;
    logic signed [PW-1:0] prod;
    logic [31:0]          em, ez;
    col3   = (col_q == COL_MOVE);
    normal = (ser_act_q == ACT_NORMAL);
    jsel   = col3 ? 2'd0 : col_q;
    s      = signed'(ser_sc_q[jsel]);
    ad     = s[15] ? 16'(-s) : 16'(s);
    zero   = normal && !col3 && (s == 16'sd0);
    iss_side_d.column_index = col_q;
    iss_side_d.last_column  = ser_last;
    iss_side_d.zero_scale   = zero;
    iss_side_d.one          = col3;
    iss_side_d.use_div      = normal && !zero;
    iss_side_d.divisor      = ad;
    for (int k = 0; k < 3; k++) begin
      r    = ser_m_q[jsel][k];
      prod = r * s;
      prod = (prod + MOD_HALF) >>> MOD_SH;
      if (prod > P_MAX) begin
        em = SAT_MAX;
      end else if (prod < P_MIN) begin
        em = SAT_MIN;
      end else begin
        em = prod[31:0];
      end
      if (r[MW-1]) begin
        ez = SAT_MIN;
      end else if (r != '0) begin
        ez = SAT_MAX;
      end else begin
        ez = '0;
      end
      rm = r[MW-1] ? MW'(-r) : MW'(r);
      iss_dq_d[k] = (DIV_BITS'(rm) << NORM_SH) + DIV_BITS'(ad >> 1);
      iss_side_d.neg[k]  = r[MW-1] ^ s[15];
      iss_side_d.elem[k] = col3 ? ser_mv_q[k] : (zero ? ez : em);
    end
  end

  // Issue register, head of the divider chain.
  logic                     is_v_q;
  col_side_t                is_side_q;
  logic [2:0][DIV_BITS-1:0] is_dq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_v_q <= 1'b0;
    end else if (en_out) begin
      is_v_q <= ser_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      is_side_q <= iss_side_d;
      is_dq_q   <= iss_dq_d;
    end
  end

  // ---------------------------------------------------------------------
  // Row of division cells, one quotient bit each.
  col_side_t                dside [DIV_BITS+1];
  logic [2:0][REM_BITS-1:0] drem  [DIV_BITS+1];
  logic [2:0][DIV_BITS-1:0] ddq   [DIV_BITS+1];
  logic [DIV_BITS-1:0]      dv_q;

  assign dside[0] = is_side_q;
  assign drem[0]  = '0;
  assign ddq[0]   = is_dq_q;

  for (genvar c = 0; c < DIV_BITS; c++) begin : g_div
    etm_div_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en_out),
      .side_i (dside[c]),
      .rem_i  (drem[c]),
      .dq_i   (ddq[c]),
      .side_o (dside[c+1]),
      .rem_o  (drem[c+1]),
      .dq_o   (ddq[c+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (en_out) begin
      dv_q <= {dv_q[DIV_BITS-2:0], is_v_q};
    end
  end

  // ---------------------------------------------------------------------
  // Output register: apply quotient signs and pick the column entries.
  col_side_t        fs;
  logic [2:0][31:0] fe_d, fe_q;
  logic [1:0]       fcol_q;
  logic             fzero_q, flast_q, fone_q;

  assign fs = dside[DIV_BITS];

  always_comb begin
    logic [31:0] qv;
    for (int k = 0; k < 3; k++) begin
      qv = 32'(ddq[DIV_BITS][k]);
      if (fs.neg[k]) begin
        qv = -qv;
      end
      fe_d[k] = fs.use_div ? qv : fs.elem[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_out) begin
      ov_q <= dv_q[DIV_BITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      fe_q    <= fe_d;
      fcol_q  <= fs.column_index;
      fzero_q <= fs.zero_scale;
      flast_q <= fs.last_column;
      fone_q  <= fs.one;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.column_index = fcol_q;
  assign out_o.elem_0       = fe_q[0];
  assign out_o.elem_1       = fe_q[1];
  assign out_o.elem_2       = fe_q[2];
  assign out_o.elem_3       = fone_q ? ONE_Q16 : 32'h0;
  assign out_o.zero_scale   = fzero_q;
  assign out_o.last_column  = flast_q;

  // ---------------------------------------------------------------------
  // Assertions.
  a_zero_no_row3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_scale |-> out_o.elem_3 == 32'h0 &&
      out_o.column_index != COL_MOVE)
    else $error("zero_scale flagged on a translation column");

  a_move_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.column_index == COL_MOVE |->
      out_o.last_column && out_o.elem_3 == ONE_Q16)
    else $error("translation column is not closing with 1.0");

  a_ser_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_v_q && !en_out |=> $stable(col_q))
    else $error("serializer column advanced during a stall");

  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> iv_q)
    else $error("input transfer not captured");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the Euler transform matrix unit.
// Depends on etm_pkg, etm_if and euler_transform_matrix_unit; predicts each
// matrix column from the transform fields and compares transfers in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import etm_pkg::*;

  localparam int unsigned ABITS    = ANGLE_BITS_DEF;
  localparam int unsigned TFRAC    = TRIG_FRAC_BITS_DEF;
  localparam int          STALL_LIMIT = 20000;
  localparam int          RAND_ITEMS  = 300;

  typedef struct packed {
    logic [1:0]  column_index;
    logic [31:0] elem_0;
    logic [31:0] elem_1;
    logic [31:0] elem_2;
    logic [31:0] elem_3;
    logic        zero_scale;
    logic        last_column;
  } column_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  etm_in_if  in_ch ();
  etm_out_if out_ch ();

  euler_transform_matrix_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  in_item_t pending_transforms[$];
  column_t  expected_columns[$];
  bit       stimulus_done = 1'b0;
  int       mismatch_count = 0;
  int       quiet_cycles = 0;
  int       cycle_count = 0;
  int       calm_from = 0;
  int       calm_to = 0;

  // Arithmetic helpers mirroring the fixed-point rules of the block.
  function automatic longint floor_shift(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic longint round_shift(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint trig_mul(longint a, longint b);
    return round_shift(a * b, TFRAC);
  endfunction

  // CORDIC sine and cosine of a binary angle, rounded to TFRAC bits.
  task automatic angle_trig(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] a;
    logic [31:0] ru;
    logic [1:0]  quad;
    longint      z, x, y, nx, t;
    a = 32'(ang & ((1 << ABITS) - 1)) << (32 - ABITS);
    quad = 2'((a + 32'h2000_0000) >> 30);
    ru = a - (32'(quad) << 30);
    z = longint'($signed(ru));
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z = z - longint'(atan_turn(i));
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z = z + longint'(atan_turn(i));
      end
      x = nx;
    end
    case (quad)
      QUAD_1: begin t = x; x = -y; y = t; end
      QUAD_2: begin x = -x; y = -y; end
      QUAD_3: begin t = x; x = y; y = -t; end
      default: ;
    endcase
    c = round_shift(x, 30 - TFRAC);
    s = round_shift(y, 30 - TFRAC);
  endtask

  // Rotation entry divided by a Q8.8 scale, rounded half away from zero.
  function automatic longint inverse_scale(longint r, longint sc);
    longint n, an, ad, q;
    if (sc == 0) return (r > 0) ? 64'sd2147483647 : ((r < 0) ? -64'sd2147483648 : 0);
    n = r * (longint'(1) <<< (24 - TFRAC));
    an = (n < 0) ? -n : n;
    ad = (sc < 0) ? -sc : sc;
    q = (an + ad / 2) / ad;
    if ((n < 0) != (sc < 0)) q = -q;
    return clamp32(q);
  endfunction

  // Builds the expected columns of one transform.
  task automatic predict_matrix(input in_item_t t);
    longint  cx, sx, cy, sy, cz, sz;
    longint  rot[3][3];
    longint  ent[4];
    longint  sc;
    column_t col;
    int      ncols;
    angle_trig(t.angle[0], cx, sx);
    angle_trig(t.angle[1], cy, sy);
    angle_trig(t.angle[2], cz, sz);
    rot[0][0] = trig_mul(cy, cz) + trig_mul(trig_mul(sy, sx), sz);
    rot[0][1] = trig_mul(cx, sz);
    rot[0][2] = trig_mul(trig_mul(cy, sx), sz) - trig_mul(cz, sy);
    rot[1][0] = trig_mul(trig_mul(cz, sy), sx) - trig_mul(cy, sz);
    rot[1][1] = trig_mul(cx, cz);
    rot[1][2] = trig_mul(trig_mul(cy, cz), sx) + trig_mul(sy, sz);
    rot[2][0] = trig_mul(cx, sy);
    rot[2][1] = -sx;
    rot[2][2] = trig_mul(cy, cx);
    ncols = (t.action == ACT_NORMAL) ? 3 : 4;
    for (int j = 0; j < ncols; j++) begin
      col = '0;
      col.column_index = 2'(j);
      if (2'(j) == COL_MOVE) begin
        for (int k = 0; k < 3; k++) ent[k] = longint'($signed(t.move[k]));
        ent[3] = longint'(ONE_Q16);
      end else begin
        sc = longint'($signed(t.scale[j]));
        for (int k = 0; k < 3; k++) begin
          if (t.action == ACT_NORMAL) ent[k] = inverse_scale(rot[j][k], sc);
          else ent[k] = clamp32(round_shift(rot[j][k] * sc, TFRAC - 8));
        end
        ent[3] = 0;
        col.zero_scale = (t.action == ACT_NORMAL) && (sc == 0);
      end
      col.elem_0 = 32'(ent[0]);
      col.elem_1 = 32'(ent[1]);
      col.elem_2 = 32'(ent[2]);
      col.elem_3 = 32'(ent[3]);
      col.last_column = (j == ncols - 1);
      expected_columns.push_back(col);
    end
  endtask

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return 16'(16'sd1 <<< $urandom_range(0, 14)) ^ {16{$urandom_range(0, 1) == 1}};
      4, 5: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_transform();
    in_item_t t;
    t.action = logic'($urandom_range(0, 1));
    for (int k = 0; k < 3; k++) begin
      t.angle[k] = ($urandom_range(0, 5) == 0) ? 16'(($urandom_range(0, 7)) << 13)
                                               : 16'($urandom);
      t.scale[k] = pick_scale();
      t.move[k] = $urandom;
    end
    return t;
  endfunction

  // Stimulus: directed corners, then random transforms.
  initial begin
    in_item_t t;
    logic [15:0] corner_angles[8];
    corner_angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                      16'hFFFF, 16'h2000, 16'hE000, 16'h5555};
    calm_from = 200 + $urandom_range(0, 200);
    calm_to = calm_from + 150;
    for (int i = 0; i < 8; i++) begin
      t.action = logic'(i & 1);
      t.angle[0] = corner_angles[i];
      t.angle[1] = corner_angles[(i + 3) % 8];
      t.angle[2] = corner_angles[(i + 5) % 8];
      t.scale = '{16'h0100, 16'h7FFF, 16'h8000};
      t.move = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000};
      pending_transforms.push_back(t);
    end
    // Zero scales in both actions, tiny scales and all-ones fields.
    for (int i = 0; i < 6; i++) begin
      t.action = (i < 3) ? ACT_NORMAL : ACT_MODEL;
      t.angle = '{16'h1234, 16'h9ABC, 16'hFEDC};
      t.scale = '{16'h0000, (i % 3 == 1) ? 16'h0001 : 16'h0000, 16'hFFFF};
      t.move = '{32'hFFFF_FFFF, 32'h0001_0000, 32'h1234_5678};
      pending_transforms.push_back(t);
    end
    t.action = ACT_NORMAL;
    t.angle = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    t.scale = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    t.move = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    pending_transforms.push_back(t);
    t.action = ACT_MODEL;
    pending_transforms.push_back(t);
    for (int i = 0; i < RAND_ITEMS; i++) pending_transforms.push_back(random_transform());
    stimulus_done = 1'b1;
  end

  // Reset sequence: rst_ni starts low and is released on a rising clock edge.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic bit calm_phase();
    return (cycle_count >= calm_from) && (cycle_count < calm_to);
  endfunction

  // Driver: holds each transfer until accepted, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.action <= 1'b0;
      {in_ch.angle_x, in_ch.angle_y, in_ch.angle_z} <= '0;
      {in_ch.scale_x, in_ch.scale_y, in_ch.scale_z} <= '0;
      {in_ch.move_x, in_ch.move_y, in_ch.move_z} <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_matrix(in_item_t'({in_ch.action,
          in_ch.angle_z, in_ch.angle_y, in_ch.angle_x,
          in_ch.scale_z, in_ch.scale_y, in_ch.scale_x,
          in_ch.move_z, in_ch.move_y, in_ch.move_x}));
      if (pending_transforms.size() > 0 && (calm_phase() || $urandom_range(0, 99) >= 9)) begin
        in_item_t t;
        t = pending_transforms.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.action <= t.action;
        in_ch.angle_x <= t.angle[0];
        in_ch.angle_y <= t.angle[1];
        in_ch.angle_z <= t.angle[2];
        in_ch.scale_x <= t.scale[0];
        in_ch.scale_y <= t.scale[1];
        in_ch.scale_z <= t.scale[2];
        in_ch.move_x <= t.move[0];
        in_ch.move_y <= t.move[1];
        in_ch.move_z <= t.move[2];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each column transfer and stalls the output at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      cycle_count <= cycle_count + 1;
      out_ch.ready <= calm_phase() || ($urandom_range(0, 99) >= 9);
      if (out_ch.valid && out_ch.ready) begin
        column_t got;
        got = {out_ch.column_index, out_ch.elem_0, out_ch.elem_1, out_ch.elem_2,
               out_ch.elem_3, out_ch.zero_scale, out_ch.last_column};
        if (expected_columns.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected column transfer: %h", got);
        end else begin
          column_t want;
          want = expected_columns.pop_front();
          if (got !== want) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display({"column mismatch: expected idx=%0d e=%h %h %h %h z=%b l=%b,",
                        " got idx=%0d e=%h %h %h %h z=%b l=%b"},
                       want.column_index, want.elem_0, want.elem_1, want.elem_2,
                       want.elem_3, want.zero_scale, want.last_column,
                       got.column_index, got.elem_0, got.elem_1, got.elem_2,
                       got.elem_3, got.zero_scale, got.last_column);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("euler_transform_matrix_unit verification failed");
      $finish;
    end
  end

  // End of run: all transforms sent, all columns seen, then drain.
  initial begin
    wait (rst_ni && stimulus_done);
    wait (pending_transforms.size() == 0 && !in_ch.valid && expected_columns.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && expected_columns.size() == 0) begin
      $display("euler_transform_matrix_unit verification clean");
    end else begin
      $display("euler_transform_matrix_unit verification failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/etm_pkg.sv
src/etm_if.sv
src/etm_cordic_cell.sv
src/etm_div_cell.sv
src/euler_transform_matrix_unit.sv
verif/tb_top.sv
